/* rtl/efe_pkg.sv */
// ----------------------------------------------------------------------------
// efe_pkg
// Shared types and constants of the escaped frame encoder: register indexes,
// reset values of the symbol and command registers, and the frame record
// that travels from the item register to the byte stuffer.
// ----------------------------------------------------------------------------
package efe_pkg;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    CFG_END_SYM    = 3'd0,
    CFG_ESC_SYM    = 3'd1,
    CFG_END_REPL   = 3'd2,
    CFG_ESC_REPL   = 3'd3,
    CFG_SINGLE_CMD = 3'd4,
    CFG_MULTI_CMD  = 3'd5
  } efe_cfg_idx_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Register reset values (SLIP symbols, default command codes)
  localparam logic [7:0] RST_END_SYM    = 8'd192;
  localparam logic [7:0] RST_ESC_SYM    = 8'd219;
  localparam logic [7:0] RST_END_REPL   = 8'd220;
  localparam logic [7:0] RST_ESC_REPL   = 8'd221;
  localparam logic [7:0] RST_SINGLE_CMD = 8'd1;
  localparam logic [7:0] RST_MULTI_CMD  = 8'd2;

  // Frame modes, taken from the command field of a frame's first item
  localparam logic MODE_SINGLE = 1'b0;
  localparam logic MODE_MULTI  = 1'b1;

  // Payload byte counts per item
  localparam logic [2:0] NB_SINGLE_FIRST = 3'd4;
  localparam logic [2:0] NB_MULTI_FIRST  = 3'd3;
  localparam logic [2:0] NB_VALUE_ONLY   = 3'd2;

  // Symbols the stuffer needs
  typedef struct packed {
    logic [7:0] end_sym;
    logic [7:0] esc_sym;
    logic [7:0] end_repl;
    logic [7:0] esc_repl;
  } efe_stuff_cfg_t;

  // One item's unstuffed payload, byte 0 goes out first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            close;
  } efe_frame_t;

endpackage

/* rtl/efe_in_if.sv */
// ----------------------------------------------------------------------------
// efe_in_if
// Input channel: one 16-bit channel value per item, with frame controls.
// ----------------------------------------------------------------------------
interface efe_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  channel;
  logic [15:0] value;
  logic        last_value;

  modport source (output valid, output command, output channel, output value,
                  output last_value, input ready);
  modport sink   (input valid, input command, input channel, input value,
                  input last_value, output ready);
endinterface

/* rtl/efe_out_if.sv */
// ----------------------------------------------------------------------------
// efe_out_if
// Output channel: one stuffed wire byte per item.
// ----------------------------------------------------------------------------
interface efe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       frame_end;

  modport source (output valid, output out_byte, output last_of_run,
                  output frame_end, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input frame_end, output ready);
endinterface

/* rtl/efe_stuffer.sv */
// ----------------------------------------------------------------------------
// efe_stuffer
// Walks one frame record byte by byte, inserting escape pairs and the closing
// end symbol, into a registered output stage. One wire byte per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module efe_stuffer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  efe_pkg::efe_stuff_cfg_t cfg,
  input  logic                   frame_valid,
  input  efe_pkg::efe_frame_t    frame,
  output logic                   frame_take,
  efe_out_if.source              out_ch
);

  // Work register: record being stuffed
  logic                ser_valid_r, ser_valid_nxt;
  efe_pkg::efe_frame_t ser_r, ser_nxt;
  logic [2:0]          idx_r, idx_nxt;
  logic                esc_phase_r, esc_phase_nxt;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       last_r, last_nxt;
  logic       fe_r, fe_nxt;

  logic       load, emit;
  logic [7:0] cur;
  logic [7:0] byte_c;
  logic       fe_c, step_done, item_done;
  logic [2:0] idx_inc;

  assign load    = !out_valid_r || out_ch.ready;
  assign emit    = ser_valid_r && load;
  assign cur     = ser_r.bytes[idx_r[1:0]];
  assign idx_inc = idx_r + 3'd1;

  // Pick the byte for this cycle
  always_comb begin
    byte_c    = cur;
    fe_c      = 1'b0;
    step_done = 1'b0;
    if (esc_phase_r) begin
      // second half of an escape pair; end match wins on a symbol clash
      byte_c    = (cur == cfg.end_sym) ? cfg.end_repl : cfg.esc_repl;
      step_done = 1'b1;
    end else if (idx_r != ser_r.nbytes) begin
      if (cur == cfg.end_sym || cur == cfg.esc_sym) begin
        byte_c = cfg.esc_sym;
      end else begin
        byte_c    = cur;
        step_done = 1'b1;
      end
    end else begin
      // payload done, close the frame
      byte_c = cfg.end_sym;
      fe_c   = 1'b1;
    end
  end

  assign item_done  = fe_c || (step_done && idx_inc == ser_r.nbytes && !ser_r.close);
  assign frame_take = !ser_valid_r || (emit && item_done);

  // Work register next state
  always_comb begin
    ser_valid_nxt = ser_valid_r;
    ser_nxt       = ser_r;
    idx_nxt       = idx_r;
    esc_phase_nxt = esc_phase_r;
    if (frame_take) begin
      ser_valid_nxt = frame_valid;
      ser_nxt       = frame;
      idx_nxt       = 3'd0;
      esc_phase_nxt = 1'b0;
    end else if (emit) begin
      if (step_done) begin
        idx_nxt       = idx_inc;
        esc_phase_nxt = 1'b0;
      end else begin
        esc_phase_nxt = 1'b1;
      end
    end
  end

  // Output register next state
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    last_nxt      = last_r;
    fe_nxt        = fe_r;
    if (load) begin
      out_valid_nxt = ser_valid_r;
      out_byte_nxt  = byte_c;
      last_nxt      = item_done;
      fe_nxt        = fe_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
      idx_r       <= 3'd0;
      esc_phase_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ser_valid_r <= ser_valid_nxt;
      idx_r       <= idx_nxt;
      esc_phase_r <= esc_phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ser_r      <= ser_nxt;
    out_byte_r <= out_byte_nxt;
    last_r     <= last_nxt;
    fe_r       <= fe_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = last_r;
  assign out_ch.frame_end   = fe_r;

endmodule

/* rtl/escaped_frame_encoder.sv */
// ----------------------------------------------------------------------------
// escaped_frame_encoder
// Servo command frame builder with SLIP-style byte stuffing.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  (valid/ready): one 16-bit channel value per item. The first item of
//          a frame picks the mode from command; single mode also sends channel.
//          A single-mode frame closes after its item, a multi-mode frame on the
//          item with last_value set.
//   out_ch (valid/ready): one wire byte per item. last_of_run marks the last
//          byte caused by an input item, frame_end marks the closing end symbol.
//   cfg_*: write-only symbol and command registers; write only while idle.
// Path: item register, then the stuffer's work register, then the output register.
// Throughput: the stuffer sends one byte per cycle while the receiver is ready;
//   an item makes 2 to 9 wire bytes (3 for a two-byte value plus end symbol); an item
//   register in front lets the next item be taken while one is being sent.
// Reset (rst_n low, synchronous): registers return to the SLIP defaults and
//   no frame is open; all items in flight are dropped.
// Receiver stall: the output byte holds, the stuffer and item register fill,
//   then in_ch.ready falls until bytes move again.
// ----------------------------------------------------------------------------
module escaped_frame_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  efe_in_if.sink                        in_ch,
  efe_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [efe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [efe_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [7:0] end_sym_r, esc_sym_r, end_repl_r, esc_repl_r;
  logic [7:0] single_cmd_r, multi_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_sym_r    <= efe_pkg::RST_END_SYM;
      esc_sym_r    <= efe_pkg::RST_ESC_SYM;
      end_repl_r   <= efe_pkg::RST_END_REPL;
      esc_repl_r   <= efe_pkg::RST_ESC_REPL;
      single_cmd_r <= efe_pkg::RST_SINGLE_CMD;
      multi_cmd_r  <= efe_pkg::RST_MULTI_CMD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        efe_pkg::CFG_END_SYM:    end_sym_r    <= cfg_data;
        efe_pkg::CFG_ESC_SYM:    esc_sym_r    <= cfg_data;
        efe_pkg::CFG_END_REPL:   end_repl_r   <= cfg_data;
        efe_pkg::CFG_ESC_REPL:   esc_repl_r   <= cfg_data;
        efe_pkg::CFG_SINGLE_CMD: single_cmd_r <= cfg_data;
        efe_pkg::CFG_MULTI_CMD:  multi_cmd_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame tracking and item register
  logic                in_frame_r, in_frame_nxt;
  logic                frame_mode_r, frame_mode_nxt;
  logic                hold_valid_r, hold_valid_nxt;
  efe_pkg::efe_frame_t hold_r, hold_nxt;
  efe_pkg::efe_frame_t frame_c;
  logic                mode_c;
  logic                accept, frame_take;
  logic [7:0]          val_lo, val_hi;

  assign val_lo = in_ch.value[7:0];
  assign val_hi = in_ch.value[15:8];
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !hold_valid_r || frame_take;

  // Build the unstuffed payload of the incoming item
  always_comb begin
    mode_c        = in_frame_r ? frame_mode_r : in_ch.command;
    frame_c.close = (mode_c == efe_pkg::MODE_SINGLE) || in_ch.last_value;
    if (!in_frame_r && mode_c == efe_pkg::MODE_SINGLE) begin
      frame_c.bytes  = {val_hi, val_lo, in_ch.channel, single_cmd_r};
      frame_c.nbytes = efe_pkg::NB_SINGLE_FIRST;
    end else if (!in_frame_r) begin
      frame_c.bytes  = {8'd0, val_hi, val_lo, multi_cmd_r};
      frame_c.nbytes = efe_pkg::NB_MULTI_FIRST;
    end else begin
      frame_c.bytes  = {8'd0, 8'd0, val_hi, val_lo};
      frame_c.nbytes = efe_pkg::NB_VALUE_ONLY;
    end
  end

  always_comb begin
    in_frame_nxt   = in_frame_r;
    frame_mode_nxt = frame_mode_r;
    hold_nxt       = hold_r;
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      in_frame_nxt   = !frame_c.close;
      frame_mode_nxt = mode_c;
      hold_nxt       = frame_c;
      hold_valid_nxt = 1'b1;
    end else if (frame_take) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      frame_mode_r <= efe_pkg::MODE_SINGLE;
      hold_valid_r <= 1'b0;
    end else begin
      in_frame_r   <= in_frame_nxt;
      frame_mode_r <= frame_mode_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

  // Byte stuffer and output stage
  efe_pkg::efe_stuff_cfg_t stuff_cfg;
  assign stuff_cfg = '{end_sym:  end_sym_r,  esc_sym:  esc_sym_r,
                       end_repl: end_repl_r, esc_repl: esc_repl_r};

  efe_stuffer u_stuffer (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (stuff_cfg),
    .frame_valid (hold_valid_r),
    .frame       (hold_r),
    .frame_take  (frame_take),
    .out_ch      (out_ch)
  );

endmodule

/* rtl/efe_checker.sv */
// ----------------------------------------------------------------------------
// efe_checker
// Port-level checks of the escaped frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
module efe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run,
  input logic       frame_end
);

  // Stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("output byte changed under stall");

  // Closing end symbol is always the last byte of its item
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_end |-> last_of_run)
    else $error("frame end without last_of_run");

  // Bytes of one item come out without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("gap inside an item's byte run");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind escaped_frame_encoder efe_checker u_efe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .last_of_run (out_ch.last_of_run),
  .frame_end   (out_ch.frame_end)
);

/* verif/efe_wire_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// efe_wire_checker
// Watches the input, output and register ports of the escaped frame encoder.
// Every accepted input item is turned into the stuffed wire bytes it should
// produce. Those bytes are queued, and each byte taken from the output
// channel is compared against the oldest one in the queue.
// ----------------------------------------------------------------------------
module efe_wire_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  efe_in_if                              in_ch,
  efe_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [efe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [efe_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             pending
);

  // One wire byte with its flags, laid out like the output payload
  typedef struct packed {
    logic [7:0] wire_byte;
    logic       run_end;
    logic       closing;
  } wire_byte_t;

  wire_byte_t wire_bytes_q [$];
  wire_byte_t run_buf [0:8];
  int         run_len;
  int         mismatch_total = 0;

  // Register copies and frame state
  logic [7:0] end_sym, esc_sym, end_repl, esc_repl, single_cmd, multi_cmd;
  logic       frame_open;
  logic       frame_mode;

  task automatic add_raw(input logic [7:0] b, input logic closing);
    run_buf[run_len] = {b, 1'b0, closing};
    run_len++;
  endtask

  // End symbol wins when both symbols are equal
  task automatic add_payload(input logic [7:0] b);
    if (b == end_sym) begin
      add_raw(esc_sym, 1'b0);
      add_raw(end_repl, 1'b0);
    end else if (b == esc_sym) begin
      add_raw(esc_sym, 1'b0);
      add_raw(esc_repl, 1'b0);
    end else begin
      add_raw(b, 1'b0);
    end
  endtask

  // Wire bytes caused by one input item
  task automatic stuff_item(input logic cmd, input logic [7:0] chan,
                            input logic [15:0] val, input logic last);
    run_len = 0;
    if (!frame_open) begin
      frame_mode = cmd;
      if (frame_mode == efe_pkg::MODE_SINGLE) begin
        add_payload(single_cmd);
        add_payload(chan);
      end else begin
        add_payload(multi_cmd);
      end
    end
    add_payload(val[7:0]);
    add_payload(val[15:8]);
    if (frame_mode == efe_pkg::MODE_SINGLE || last) begin
      add_raw(end_sym, 1'b1);
      frame_open = 1'b0;
    end else begin
      frame_open = 1'b1;
    end
    run_buf[run_len-1].run_end = 1'b1;
    for (int i = 0; i < run_len; i++) wire_bytes_q.push_back(run_buf[i]);
  endtask

  task automatic report(input string msg);
    mismatch_total++;
    if (mismatch_total <= 10) $display("%0t %s", $time, msg);
  endtask

  always @(posedge clk) begin : scoreboard
    wire_byte_t seen, want;
    if (!rst_n) begin
      end_sym    = efe_pkg::RST_END_SYM;
      esc_sym    = efe_pkg::RST_ESC_SYM;
      end_repl   = efe_pkg::RST_END_REPL;
      esc_repl   = efe_pkg::RST_ESC_REPL;
      single_cmd = efe_pkg::RST_SINGLE_CMD;
      multi_cmd  = efe_pkg::RST_MULTI_CMD;
      frame_open = 1'b0;
      frame_mode = efe_pkg::MODE_SINGLE;
      wire_bytes_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          efe_pkg::CFG_END_SYM:    end_sym    = cfg_data;
          efe_pkg::CFG_ESC_SYM:    esc_sym    = cfg_data;
          efe_pkg::CFG_END_REPL:   end_repl   = cfg_data;
          efe_pkg::CFG_ESC_REPL:   esc_repl   = cfg_data;
          efe_pkg::CFG_SINGLE_CMD: single_cmd = cfg_data;
          efe_pkg::CFG_MULTI_CMD:  multi_cmd  = cfg_data;
          default: ;
        endcase
      end

      // accepted input item
      if (in_ch.valid && in_ch.ready)
        stuff_item(in_ch.command, in_ch.channel, in_ch.value, in_ch.last_value);

      // accepted output byte
      if (out_ch.valid && out_ch.ready) begin
        seen = {out_ch.out_byte, out_ch.last_of_run, out_ch.frame_end};
        if (wire_bytes_q.size() == 0) begin
          report($sformatf("unexpected byte %02h last_of_run %0b frame_end %0b",
                           seen.wire_byte, seen.run_end, seen.closing));
        end else begin
          want = wire_bytes_q.pop_front();
          if (seen.wire_byte !== want.wire_byte)
            report($sformatf("out_byte: expected %02h, got %02h",
                             want.wire_byte, seen.wire_byte));
          if (seen.run_end !== want.run_end)
            report($sformatf("last_of_run on byte %02h: expected %0b, got %0b",
                             want.wire_byte, want.run_end, seen.run_end));
          if (seen.closing !== want.closing)
            report($sformatf("frame_end on byte %02h: expected %0b, got %0b",
                             want.wire_byte, want.closing, seen.closing));
        end
      end
    end
    pending    <= wire_bytes_q.size();
    mismatches <= mismatch_total;
  end

endmodule

/* verif/escaped_frame_encoder_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// escaped_frame_encoder_test
// Testbench top for the escaped frame encoder. It starts with directed frames
// that hit the field extremes, both modes and the escaping of both symbols.
// Random frames follow under several register settings: reset defaults, all
// zero, all ones, swapped symbols, and random values. Random payload bytes
// lean toward the symbol and replacement values so escapes come often. Both
// handshakes idle at random. The checker beside the block flags failures.
// ----------------------------------------------------------------------------
module escaped_frame_encoder_test;

  localparam int CLK_PERIOD = 20;
  localparam int TIMEOUT_NS = 2_000_000;
  localparam int SETTLE     = 8;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [efe_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [efe_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           steady;
  int                             mismatches;
  int                             pending;
  bit                             hold_done = 1'b0;

  // Register values currently in the block, used to bias random bytes
  logic [7:0] end_sym_now, esc_sym_now, end_repl_now, esc_repl_now;

  efe_in_if  in_ch ();
  efe_out_if out_ch ();

  escaped_frame_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  efe_wire_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver: stalls about 30% of cycles unless in a steady stretch
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 30);
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[escaped_frame_encoder] ERROR");
    $finish;
  end

  // Payload byte biased toward the symbols, replacements and extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return end_sym_now;
      1:       return esc_sym_now;
      2:       return end_repl_now;
      3:       return esc_repl_now;
      4:       return 8'h00;
      5:       return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Hold the write enable across back-to-back writes; caller lowers it
  task automatic put_reg(input efe_pkg::efe_cfg_idx_t idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] e, input logic [7:0] s,
                                input logic [7:0] er, input logic [7:0] sr,
                                input logic [7:0] sc, input logic [7:0] mc);
    put_reg(efe_pkg::CFG_END_SYM, e);
    put_reg(efe_pkg::CFG_ESC_SYM, s);
    put_reg(efe_pkg::CFG_END_REPL, er);
    put_reg(efe_pkg::CFG_ESC_REPL, sr);
    put_reg(efe_pkg::CFG_SINGLE_CMD, sc);
    put_reg(efe_pkg::CFG_MULTI_CMD, mc);
    cfg_we       <= 1'b0;
    end_sym_now  = e;
    esc_sym_now  = s;
    end_repl_now = er;
    esc_repl_now = sr;
    @(posedge clk);
  endtask

  // Valid stays high after a handshake so items can go back to back
  task automatic send_item(input logic cmd, input logic [7:0] chan,
                           input logic [15:0] val, input logic last);
    if (!steady && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.channel    <= chan;
    in_ch.value      <= val;
    in_ch.last_value <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop sending until every queued wire byte has come out
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random frames: single-channel ones and multi-channel runs of 1 to 6 items
  task automatic send_random_frames(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 45) begin
        send_item(efe_pkg::MODE_SINGLE, pick_byte(), {pick_byte(), pick_byte()},
                  1'($urandom_range(1)));
        sent++;
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          // once, hold off in the middle of an open frame until all is out
          if (k == 1 && !hold_done) begin
            wait_for_drain();
            hold_done = 1'b1;
          end
          // command and channel of later items are don't-care
          send_item(k == 0 ? efe_pkg::MODE_MULTI : 1'($urandom_range(1)),
                    pick_byte(), {pick_byte(), pick_byte()}, k == len - 1);
          sent++;
        end
      end
    end
  endtask

  task automatic end_phase();
    wait_for_drain();
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    steady           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= efe_pkg::MODE_SINGLE;
    in_ch.channel    <= '0;
    in_ch.value      <= '0;
    in_ch.last_value <= 1'b0;
    end_sym_now      = efe_pkg::RST_END_SYM;
    esc_sym_now      = efe_pkg::RST_ESC_SYM;
    end_repl_now     = efe_pkg::RST_END_REPL;
    esc_repl_now     = efe_pkg::RST_ESC_REPL;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames under reset defaults
    send_item(efe_pkg::MODE_SINGLE, 8'h00, 16'h0000, 1'b0);
    send_item(efe_pkg::MODE_SINGLE, 8'hff, 16'hffff, 1'b1);   // last ignored in single mode
    send_item(efe_pkg::MODE_SINGLE, efe_pkg::RST_END_SYM,
              {efe_pkg::RST_ESC_SYM, efe_pkg::RST_END_SYM}, 1'b0);
    send_item(efe_pkg::MODE_SINGLE, efe_pkg::RST_ESC_SYM,
              {efe_pkg::RST_END_SYM, efe_pkg::RST_ESC_SYM}, 1'b0);
    send_item(efe_pkg::MODE_SINGLE, efe_pkg::RST_END_REPL,
              {efe_pkg::RST_ESC_REPL, efe_pkg::RST_END_REPL}, 1'b0);
    send_item(efe_pkg::MODE_MULTI, 8'h33, 16'h1234, 1'b1);    // one-item multi frame
    send_item(efe_pkg::MODE_MULTI, 8'h01, 16'h00ff, 1'b0);
    send_item(efe_pkg::MODE_SINGLE, efe_pkg::RST_END_SYM,
              {efe_pkg::RST_END_SYM, efe_pkg::RST_END_SYM}, 1'b0);
    send_item(efe_pkg::MODE_MULTI, 8'h07,
              {efe_pkg::RST_ESC_SYM, efe_pkg::RST_ESC_SYM}, 1'b1);
    send_item(efe_pkg::MODE_MULTI, 8'haa, 16'hff00, 1'b0);
    send_item(efe_pkg::MODE_SINGLE, 8'h55, 16'ha55a, 1'b1);
    send_item(efe_pkg::MODE_SINGLE, 8'h5a, 16'h8001, 1'b1);
    send_item(efe_pkg::MODE_MULTI, 8'h80, 16'h7ffe, 1'b0);
    send_item(efe_pkg::MODE_MULTI, 8'h7f, 16'h0180, 1'b0);
    send_item(efe_pkg::MODE_MULTI, 8'hc3, 16'hdcdd, 1'b1);
    send_random_frames(20);
    end_phase();

    // All registers zero: both symbols clash, long stretch without idling
    apply_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    steady <= 1'b1;
    send_random_frames(15);
    end_phase();
    steady <= 1'b0;

    // All registers at the top of their range
    apply_settings(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_random_frames(15);
    end_phase();

    // Swapped symbols, command codes equal to the symbols
    apply_settings(efe_pkg::RST_ESC_SYM, efe_pkg::RST_END_SYM,
                   efe_pkg::RST_END_SYM, efe_pkg::RST_ESC_SYM,
                   efe_pkg::RST_END_SYM, efe_pkg::RST_ESC_SYM);
    send_random_frames(20);
    end_phase();

    // Random settings
    apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
    send_random_frames(25);
    end_phase();

    if (mismatches == 0) begin
      $display("[escaped_frame_encoder] OK");
    end else begin
      $display("[escaped_frame_encoder] ERROR");
    end
    $finish;
  end

endmodule
